[src/fatan_pkg.sv]
// Shared constants and types for the pipelined second-order polynomial atan2.
// Used by fast_atan2_polynomial_top; depends on nothing else.
package fatan_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int OUT_WIDTH       = ANGLE_FRAC_BITS + 3;

    localparam int MAG_WIDTH = SAMPLE_WIDTH;
    localparam int REM_WIDTH = SAMPLE_WIDTH + 1;

    localparam int Z_FRAC        = 15;
    localparam int Z_WIDTH       = Z_FRAC + 1;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = Z_WIDTH / DIV_PER_STAGE;

    localparam int ZSQ_WIDTH  = 2 * Z_WIDTH;
    localparam int COEF_WIDTH = 16;
    localparam int P_WIDTH    = COEF_WIDTH + ZSQ_WIDTH;
    localparam int T_WIDTH    = COEF_WIDTH + 2 * Z_FRAC - 1;
    localparam int T_LO_WIDTH = 23;
    localparam int T_HI_WIDTH = T_WIDTH - T_LO_WIDTH;
    localparam int PL_WIDTH   = T_LO_WIDTH + Z_WIDTH;
    localparam int PH_WIDTH   = T_HI_WIDTH + Z_WIDTH;
    localparam int ANG_WIDTH  = 64;
    localparam int DROP_BITS  = 60 - ANGLE_FRAC_BITS;

    localparam logic [COEF_WIDTH-1:0] COEF1 = 16'd31863;
    localparam logic [COEF_WIDTH-1:0] COEF2 = 16'd6290;
    localparam logic [T_WIDTH-1:0]    COEF1_SHIFTED = T_WIDTH'(COEF1) << (2 * Z_FRAC);

    localparam logic [ANG_WIDTH-1:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [ANG_WIDTH-1:0] HALF_PI_Q60 = PI_Q60 >> 1;
    localparam logic [ANG_WIDTH-1:0] ROUND_HALF  = 64'd1 << (DROP_BITS - 1);
    localparam logic [ANG_WIDTH-1:0] LIM_FULL    = (PI_Q60 + ROUND_HALF) >> DROP_BITS;
    localparam logic [OUT_WIDTH-1:0] ANGLE_LIMIT = LIM_FULL[OUT_WIDTH-1:0];

    localparam int DIV_FIRST   = 2;
    localparam int SQ_STAGE    = DIV_FIRST + DIV_STAGES;
    localparam int SIDE_LAST   = SQ_STAGE + 4;
    localparam int PIPE_DEPTH  = SIDE_LAST + 5;

    typedef enum logic [2:0] {
        OFF_NONE,
        OFF_POS_PI,
        OFF_NEG_PI,
        OFF_POS_HALF,
        OFF_NEG_HALF
    } t_off;

    typedef struct packed {
        logic zero;
        logic neg;
        t_off off;
    } t_side;

endpackage

[src/fast_atan2_polynomial_top.sv]
// Pipelined atan2 by second-order polynomial: magnitude sort, pipelined restoring
// divider, split multipliers, octant correction, rounding and saturation.
// Depends on fatan_pkg.
//
//  Channel   Handshake                Payload
//  input     start, busy (always 0)   i_x_sample, i_y_sample
//  result    o_strobe (one cycle)     o_phase_angle
//
// One transfer can be taken in every cycle; busy never rises.
// Each result appears in the order of its transfer.
// The pipeline holds the divider, two quotient bits per stage over eight
// stages, and the multiplier chain that follows it.
// Synchronous active-low reset clears the valid bits; data registers are not reset.
module fast_atan2_polynomial_top
    import fatan_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y_sample,
    output logic                           o_strobe,
    output logic signed [OUT_WIDTH-1:0]    o_phase_angle
);

    function automatic logic [REM_WIDTH:0] div_step(
        input logic [REM_WIDTH-1:0] rem,
        input logic [REM_WIDTH-1:0] den
    );
        logic                 q;
        logic [REM_WIDTH-1:0] r;
        q = (rem >= den);
        r = q ? (rem - den) : rem;
        return {q, r[REM_WIDTH-2:0], 1'b0};
    endfunction

    logic [PIPE_DEPTH-1:0] r_vld;
    t_side                 r_side [1:SIDE_LAST];

    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y;

    logic [REM_WIDTH-1:0] r_nm, r_dm;
    t_side                n_side1;
    logic [REM_WIDTH-1:0] n_nm, n_dm;

    logic [REM_WIDTH-1:0] r_rem [0:DIV_STAGES-1];
    logic [REM_WIDTH-1:0] r_den [0:DIV_STAGES-1];
    logic [Z_WIDTH-1:0]   r_quo [0:DIV_STAGES-1];
    logic [REM_WIDTH-1:0] n_rem [0:DIV_STAGES-1];
    logic [Z_WIDTH-1:0]   n_quo [0:DIV_STAGES-1];

    logic [ZSQ_WIDTH-1:0]  r_zsq;
    logic [P_WIDTH-1:0]    r_prod;
    logic [T_WIDTH-1:0]    r_t;
    logic [Z_WIDTH-1:0]    r_zm [0:2];
    logic [PL_WIDTH-1:0]   r_pl;
    logic [PH_WIDTH-1:0]   r_ph;
    logic [ANG_WIDTH-1:0]  r_a;
    logic signed [ANG_WIDTH-1:0] r_ang;
    logic signed [ANG_WIDTH-1:0] n_ang;
    logic [ANG_WIDTH-2:0]  r_mag;
    logic [1:0]            r_neg;
    logic [OUT_WIDTH-1:0]  r_rnd;
    logic signed [OUT_WIDTH-1:0] r_out;

    logic [MAG_WIDTH-1:0] mag_x, mag_y;
    logic                 x_branch, x_neg, y_neg, ratio_neg;
    logic [ANG_WIDTH-1:0] round_sum;
    logic [OUT_WIDTH-1:0] sat_val;

    assign busy = 1'b0;

    always_comb begin
        x_neg     = r_x[SAMPLE_WIDTH-1];
        y_neg     = r_y[SAMPLE_WIDTH-1];
        mag_x     = x_neg ? MAG_WIDTH'(-r_x) : MAG_WIDTH'(r_x);
        mag_y     = y_neg ? MAG_WIDTH'(-r_y) : MAG_WIDTH'(r_y);
        x_branch  = (mag_x > mag_y);
        ratio_neg = x_neg ^ y_neg;
        n_side1.zero = (mag_x == '0) && (mag_y == '0);
        if (x_branch) begin
            n_nm         = REM_WIDTH'(mag_y);
            n_dm         = REM_WIDTH'(mag_x);
            n_side1.neg  = ratio_neg;
            if (!x_neg) begin
                n_side1.off = OFF_NONE;
            end else if (!y_neg) begin
                n_side1.off = OFF_POS_PI;
            end else begin
                n_side1.off = OFF_NEG_PI;
            end
        end else begin
            n_nm         = REM_WIDTH'(mag_x);
            n_dm         = REM_WIDTH'(mag_y);
            n_side1.neg  = !ratio_neg;
            n_side1.off  = (!y_neg && (mag_y != '0)) ? OFF_POS_HALF : OFF_NEG_HALF;
        end
    end

    always_comb begin
        logic [REM_WIDTH-1:0] rem;
        logic [Z_WIDTH-1:0]   quo;
        logic [REM_WIDTH-1:0] den;
        logic [REM_WIDTH:0]   step;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                rem = r_nm;
                quo = '0;
                den = r_dm;
            end else begin
                rem = r_rem[j-1];
                quo = r_quo[j-1];
                den = r_den[j-1];
            end
            for (int i = 0; i < DIV_PER_STAGE; i++) begin
                step = div_step(rem, den);
                quo  = {quo[Z_WIDTH-2:0], step[REM_WIDTH]};
                rem  = step[REM_WIDTH-1:0];
            end
            n_rem[j] = rem;
            n_quo[j] = quo;
        end
    end

    always_comb begin
        logic signed [ANG_WIDTH-1:0] sa;
        sa = r_side[SIDE_LAST].neg ? -signed'(r_a) : signed'(r_a);
        case (r_side[SIDE_LAST].off)
            OFF_POS_PI:   n_ang = sa + signed'(PI_Q60);
            OFF_NEG_PI:   n_ang = sa - signed'(PI_Q60);
            OFF_POS_HALF: n_ang = sa + signed'(HALF_PI_Q60);
            OFF_NEG_HALF: n_ang = sa - signed'(HALF_PI_Q60);
            default:      n_ang = sa;
        endcase
        if (r_side[SIDE_LAST].zero) begin
            n_ang = '0;
        end
    end

    assign round_sum = ANG_WIDTH'(r_mag) + ROUND_HALF;
    assign sat_val   = (r_rnd > ANGLE_LIMIT) ? ANGLE_LIMIT : r_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], start & !busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= i_x_sample;
        r_y <= i_y_sample;

        r_nm      <= n_nm;
        r_dm      <= n_dm;
        r_side[1] <= n_side1;
        for (int k = 2; k <= SIDE_LAST; k++) begin
            r_side[k] <= r_side[k-1];
        end

        for (int j = 0; j < DIV_STAGES; j++) begin
            r_rem[j] <= n_rem[j];
            r_quo[j] <= n_quo[j];
            r_den[j] <= (j == 0) ? r_dm : r_den[(j == 0) ? 0 : j-1];
        end

        r_zsq   <= ZSQ_WIDTH'(r_quo[DIV_STAGES-1] * r_quo[DIV_STAGES-1]);
        r_zm[0] <= r_quo[DIV_STAGES-1];
        r_prod  <= P_WIDTH'(COEF2) * P_WIDTH'(r_zsq);
        r_zm[1] <= r_zm[0];
        r_t     <= COEF1_SHIFTED - r_prod[T_WIDTH-1:0];
        r_zm[2] <= r_zm[1];
        r_pl    <= PL_WIDTH'(r_t[T_LO_WIDTH-1:0] * r_zm[2]);
        r_ph    <= PH_WIDTH'(r_t[T_WIDTH-1:T_LO_WIDTH] * r_zm[2]);
        r_a     <= (ANG_WIDTH'(r_ph) << T_LO_WIDTH) + ANG_WIDTH'(r_pl);

        r_ang    <= n_ang;
        r_neg[0] <= r_ang[ANG_WIDTH-1];
        r_mag    <= r_ang[ANG_WIDTH-1] ? (ANG_WIDTH-1)'(-r_ang) : (ANG_WIDTH-1)'(r_ang);
        r_neg[1] <= r_neg[0];
        r_rnd    <= round_sum[DROP_BITS+OUT_WIDTH-1:DROP_BITS];
        r_out    <= r_neg[1] ? -signed'(sat_val) : signed'(sat_val);
    end

    assign o_strobe      = r_vld[PIPE_DEPTH-1];
    assign o_phase_angle = r_out;

endmodule

[test/tb_fast_atan2_polynomial_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fast_atan2_polynomial_top: a directed table and then random I/Q
// pairs, each result compared with a fixed-point atan2 predictor kept in this file or a typed angle.
// Depends on fatan_pkg and fast_atan2_polynomial_top.
module tb_fast_atan2_polynomial_top
    import fatan_pkg::*;
();

    localparam longint unsigned PI_FX60      = 64'h3243F6A8885A308D;
    localparam longint unsigned HALF_PI_FX60 = PI_FX60 >> 1;
    localparam longint unsigned POLY_C1      = 64'd31863;
    localparam longint unsigned POLY_C2      = 64'd6290;
    localparam int              ANGLE_SHIFT  = 60 - ANGLE_FRAC_BITS;
    localparam longint unsigned ANGLE_RND    = 64'd1 << (ANGLE_SHIFT - 1);
    localparam int              RAND_PER_PHASE = 510;
    localparam int              DRAIN_CYCLES   = 40;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
        logic signed [OUT_WIDTH-1:0]    angle;
    } t_phase_rec;

    typedef struct {
        int x;
        int y;
        bit known;
        int angle;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic signed [SAMPLE_WIDTH-1:0] i_x_sample;
    logic signed [SAMPLE_WIDTH-1:0] i_y_sample;
    logic                           o_strobe;
    logic signed [OUT_WIDTH-1:0]    o_phase_angle;

    logic                           angle_typed;
    logic signed [OUT_WIDTH-1:0]    typed_angle;

    t_phase_rec pending_phases[$];
    int         errors = 0;

    t_dir_row directed_rows [0:23] = '{
        '{0, 0, 1, 0},
        '{0, 1, 1, 6434},
        '{0, -1, 1, -6434},
        '{0, 32767, 1, 6434},
        '{0, -32768, 1, -6434},
        '{1, 0, 1, 0},
        '{32767, 0, 1, 0},
        '{-1, 0, 1, 12868},
        '{-32768, 0, 1, 12868},
        '{1000, 1000, 0, 0},
        '{-1000, 1000, 0, 0},
        '{-1000, -1000, 0, 0},
        '{1000, -1000, 0, 0},
        '{-32768, -32768, 0, 0},
        '{32767, -32768, 0, 0},
        '{-32768, 32767, 0, 0},
        '{-32768, 1, 0, 0},
        '{-32768, -1, 0, 0},
        '{32767, 1, 0, 0},
        '{1, 32767, 0, 0},
        '{-1, -32768, 0, 0},
        '{32767, 32767, 0, 0},
        '{12345, -321, 0, 0},
        '{-7, 5, 0, 0}
    };

    fast_atan2_polynomial_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x_sample    (i_x_sample),
        .i_y_sample    (i_y_sample),
        .o_strobe      (o_strobe),
        .o_phase_angle (o_phase_angle)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Signed atan of num/den in Q.60, with |num| <= |den|.
    function automatic longint ratio_atan_fx(input longint num, input longint den);
        longint unsigned nm;
        longint unsigned dm;
        longint unsigned z;
        longint unsigned t;
        longint unsigned poly;
        longint          a;
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        if (dm == 0) return 0;
        z = (nm << 15) / dm;
        if (z > 64'd32768) z = 64'd32768;
        t = (POLY_C1 << 30) - POLY_C2 * z * z;
        poly = t * z;
        a = $signed(poly);
        return ((num < 0) != (den < 0)) ? -a : a;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] phase_of_pair(
        input logic signed [SAMPLE_WIDTH-1:0] xs,
        input logic signed [SAMPLE_WIDTH-1:0] ys
    );
        longint          sx;
        longint          sy;
        longint          ang;
        longint unsigned mx;
        longint unsigned my;
        longint unsigned mag;
        longint unsigned lim;
        sx = xs;
        sy = ys;
        mx = (sx < 0) ? -sx : sx;
        my = (sy < 0) ? -sy : sy;
        if (sx == 0) begin
            if (sy > 0) ang = HALF_PI_FX60;
            else if (sy < 0) ang = -HALF_PI_FX60;
            else ang = 0;
        end else if (mx > my) begin
            ang = ratio_atan_fx(sy, sx);
            if (sx < 0) ang = (sy >= 0) ? ang + PI_FX60 : ang - PI_FX60;
        end else begin
            ang = -ratio_atan_fx(sx, sy);
            ang = (sy > 0) ? ang + HALF_PI_FX60 : ang - HALF_PI_FX60;
        end
        mag = (ang < 0) ? -ang : ang;
        mag = (mag + ANGLE_RND) >> ANGLE_SHIFT;
        lim = (PI_FX60 + ANGLE_RND) >> ANGLE_SHIFT;
        if (mag > lim) mag = lim;
        if (ang < 0) mag = -mag;
        return mag[OUT_WIDTH-1:0];
    endfunction

    // Input transfers are recorded before results are checked, so ordering holds at any latency.
    always @(posedge i_clk) begin
        t_phase_rec rec;
        t_phase_rec head;
        if (i_rst_n && start && busy === 1'b0) begin
            rec.x = i_x_sample;
            rec.y = i_y_sample;
            rec.angle = angle_typed ? typed_angle : phase_of_pair(i_x_sample, i_y_sample);
            pending_phases.push_back(rec);
        end
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_phases.size() == 0) begin
                $display("%0t: result transfer with nothing expected, got %0d",
                         $time, o_phase_angle);
                errors++;
            end else begin
                head = pending_phases.pop_front();
                if (o_strobe !== 1'b1 || o_phase_angle !== head.angle) begin
                    $display("%0t: phase mismatch for x=%0d y=%0d: expected %0d, got %0d",
                             $time, head.x, head.y, head.angle, o_phase_angle);
                    errors++;
                end
            end
        end
    end

    task automatic send_pair(
        input logic signed [SAMPLE_WIDTH-1:0] xs,
        input logic signed [SAMPLE_WIDTH-1:0] ys,
        input bit                             known,
        input int                             angle,
        input int                             idle_pct
    );
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_x_sample  <= xs;
        i_y_sample  <= ys;
        angle_typed <= known;
        typed_angle <= angle[OUT_WIDTH-1:0];
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pick_pair(
        output logic signed [SAMPLE_WIDTH-1:0] xs,
        output logic signed [SAMPLE_WIDTH-1:0] ys
    );
        int m;
        int n;
        xs = SAMPLE_WIDTH'($urandom);
        ys = SAMPLE_WIDTH'($urandom);
        case ($urandom_range(0, 7))
            4: begin
                xs = SAMPLE_WIDTH'($urandom_range(0, 32) - 16);
                ys = SAMPLE_WIDTH'($urandom_range(0, 32) - 16);
            end
            5: begin
                m = $urandom_range(1, 32768);
                n = m + $urandom_range(0, 4) - 2;
                if (n > 32768) n = 32768;
                xs = SAMPLE_WIDTH'($urandom_range(0, 1) ? -m : m);
                ys = SAMPLE_WIDTH'($urandom_range(0, 1) ? -n : n);
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: xs = '0;
                    1: ys = '0;
                    2: xs = SAMPLE_WIDTH'($urandom_range(0, 1) ? -32768 : 32767);
                    default: ys = SAMPLE_WIDTH'($urandom_range(0, 1) ? -32768 : 32767);
                endcase
            end
            7: begin
                if ($urandom_range(0, 1)) ys = SAMPLE_WIDTH'($urandom_range(0, 8) - 4);
                else xs = SAMPLE_WIDTH'($urandom_range(0, 8) - 4);
            end
            default: ;
        endcase
    endtask

    initial begin
        logic signed [SAMPLE_WIDTH-1:0] rx;
        logic signed [SAMPLE_WIDTH-1:0] ry;
        int idle_pct;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_x_sample  <= '0;
        i_y_sample  <= '0;
        angle_typed <= 1'b0;
        typed_angle <= '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_pair(SAMPLE_WIDTH'(directed_rows[i].x), SAMPLE_WIDTH'(directed_rows[i].y),
                      directed_rows[i].known, directed_rows[i].angle, 8);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 8 : (phase == 1) ? 76 : 0;
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                pick_pair(rx, ry);
                send_pair(rx, ry, 1'b0, 0, idle_pct);
            end
        end
        start <= 1'b0;

        while (pending_phases.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
